// ----- hw/rtl/tbl_pkg.sv -----
// Shared types and constants for the tagged bank locator.
// Used by tagged_bank_locator_core; no dependencies.
package tbl_pkg;

    localparam int MAX_WORDS_DEF = 1048576;

    localparam int IDX_W   = 20;
    localparam int BYTES_W = 22;
    localparam int CFG_W   = 2;

    localparam logic [IDX_W-1:0]   IDX_MAX   = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // bank type codes
    localparam logic [5:0] TYPE_CONT_A = 6'h0e;
    localparam logic [5:0] TYPE_CONT_B = 6'h10;
    localparam logic [5:0] TYPE_COMPOS = 6'h0f;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_FRAGMENT_TAG = 2'd0;
    localparam logic [CFG_W-1:0] CFG_BANK_TAG     = 2'd1;
    localparam logic [CFG_W-1:0] CFG_BANK_NUMBER  = 2'd2;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_SEEK,
        PH_HDR2,
        PH_TSEG,
        PH_PAD,
        PH_DONE
    } t_phase;

endpackage

// ----- hw/rtl/tagged_bank_locator_core.sv -----
// Tagged bank locator: scans an event word stream for a tagged bank header.
// Depends on tbl_pkg.
//
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one event word per item,
//   with i_last_word set on the final word of the event.
//   Output channel (o_out_valid / i_out_ready) carries at most one result per
//   event: found with payload word index and byte count, or not-found on the
//   last word if nothing matched.
//   Config channel (i_cfg_valid / o_cfg_ready) writes fragment tag, bank tag
//   and bank number; always ready, write only between events.
// Timing:
//   One word per cycle sustained while no result is stalled. A word is held
//   in an input register, then parsed by combinational compare/add logic;
//   its result is loaded into the output register as the word advances.
//   When the receiver stalls with a result pending, at most one more word is
//   taken into the input register, then o_in_ready drops until the result leaves.
// Reset:
//   Clears parse state and configuration; the next word is taken as the
//   event length word.
module tagged_bank_locator_core
    import tbl_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_data_word,
    input  logic               i_last_word,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_data_index,
    output logic [BYTES_W-1:0] o_byte_count,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int PW = $clog2(MAX_WORDS + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_WORDS);
    localparam logic [32:0]   LIM33   = 33'(MAX_WORDS);
    // from this word count up the byte count saturates whatever the pad
    localparam logic [33:0]   WCLAMP  = 34'd1048577;

    // configuration
    logic [15:0] r_frag_tag;
    logic [15:0] r_bank_tag;
    logic [7:0]  r_bank_num;

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_last;

    // parse state
    t_phase      r_phase,  n_phase;
    logic [PW-1:0] r_pos,  n_pos;
    logic [32:0] r_end,    n_end;
    logic [32:0] r_nhp,    n_nhp;
    logic        r_frag,   n_frag;
    logic [32:0] r_count,  n_count;
    logic [16:0] r_tlen,   n_tlen;
    logic        r_given,  n_given;

    // output register
    logic               r_out_valid;
    logic               r_found,  n_found;
    logic [IDX_W-1:0]   r_index,  n_index;
    logic [BYTES_W-1:0] r_bytes,  n_bytes;

    logic        advance;
    logic        out_load;
    logic        emit_try;
    logic        emit_ok;
    logic        take_cnt;
    t_phase      phase_eff;
    logic [32:0] pos33;
    logic [32:0] idx33;
    logic [32:0] skip_next;
    logic [33:0] words;
    logic [1:0]  pad;
    logic [20:0] wclamp;
    logic [22:0] bval;
    logic [15:0] d_tag;
    logic [5:0]  d_type;
    logic [7:0]  d_num;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_data_index = r_index;
    assign o_byte_count = r_bytes;

    assign d_tag  = r_in_word[31:16];
    assign d_type = r_in_word[13:8];
    assign d_num  = r_in_word[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_tag <= '0;
            r_bank_tag <= '0;
            r_bank_num <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAGMENT_TAG: r_frag_tag <= i_cfg_data;
                CFG_BANK_TAG:     r_bank_tag <= i_cfg_data;
                CFG_BANK_NUMBER:  r_bank_num <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_data_word;
            r_in_last <= i_last_word;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_end     = r_end;
        n_nhp     = r_nhp;
        n_frag    = r_frag;
        n_count   = r_count;
        n_tlen    = r_tlen;
        n_given   = r_given;
        emit_try  = 1'b0;
        take_cnt  = 1'b0;
        idx33     = '0;
        words     = '0;
        pad       = '0;
        pos33     = 33'(r_pos);
        skip_next = pos33 - 33'd1 + r_count;

        phase_eff = (r_phase != PH_DONE && r_pos >= POS_MAX) ? PH_DONE : r_phase;

        case (phase_eff)
            PH_LEN: begin
                n_end   = {1'b0, r_in_word} + 33'd1;
                n_nhp   = 33'd2;
                n_phase = (r_in_word <= 32'd1) ? PH_DONE : PH_SEEK;
            end
            PH_SEEK: begin
                take_cnt = (pos33 == r_nhp);
            end
            PH_HDR2: begin
                if (d_type == TYPE_CONT_A || d_type == TYPE_CONT_B) begin
                    n_frag  = (d_tag == r_frag_tag);
                    n_nhp   = pos33 + 33'd1;
                    n_phase = PH_SEEK;
                end else if (r_frag && d_tag == r_bank_tag && d_num == r_bank_num) begin
                    if (d_type != TYPE_COMPOS) begin
                        emit_try = 1'b1;
                        idx33    = pos33 + 33'd1;
                        words    = {1'b0, r_count} - 34'd2;
                    end else begin
                        n_phase = PH_TSEG;
                    end
                end else begin
                    n_nhp = skip_next;
                    // zero count word: this same word opens the next header
                    if (skip_next == pos33) begin
                        take_cnt = 1'b1;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
            end
            PH_TSEG: begin
                n_tlen  = {1'b0, r_in_word[15:0]} + 17'd1;
                n_nhp   = pos33 + 33'(r_in_word[15:0]) + 33'd2;
                n_phase = PH_PAD;
            end
            PH_PAD: begin
                if (pos33 == r_nhp) begin
                    emit_try = 1'b1;
                    idx33    = pos33 + 33'd1;
                    words    = {1'b0, r_count} - 34'(r_tlen) - 34'd4;
                    pad      = r_in_word[15:14];
                end
            end
            default: ;
        endcase

        if (take_cnt) begin
            if (pos33 >= r_end) begin
                n_phase = PH_DONE;
            end else begin
                n_count = {1'b0, r_in_word} + 33'd1;
                n_phase = PH_HDR2;
            end
        end

        emit_ok = emit_try && (idx33 < LIM33) && (idx33 <= 33'(IDX_MAX));
        if (emit_try) begin
            n_phase = PH_DONE;
        end
        if (emit_ok) begin
            n_given = 1'b1;
        end

        // byte count with clamp at zero and saturation
        wclamp = (words > WCLAMP) ? WCLAMP[20:0] : words[20:0];
        bval   = {wclamp, 2'b00} - 23'(pad);
        if (words[33] || words == '0) begin
            n_bytes = '0;
        end else if (bval > 23'(BYTES_MAX)) begin
            n_bytes = BYTES_MAX;
        end else begin
            n_bytes = bval[BYTES_W-1:0];
        end

        n_found  = emit_ok;
        n_index  = idx33[IDX_W-1:0];
        out_load = emit_ok;

        if (r_pos < POS_MAX) begin
            n_pos = r_pos + PW'(1);
        end

        if (r_in_last) begin
            if (!r_given && !emit_ok) begin
                out_load = 1'b1;
                n_index  = '0;
                n_bytes  = '0;
            end
            n_phase = PH_LEN;
            n_pos   = '0;
            n_end   = '0;
            n_nhp   = 33'd2;
            n_frag  = 1'b0;
            n_count = '0;
            n_tlen  = '0;
            n_given = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_pos   <= '0;
            r_end   <= '0;
            r_nhp   <= 33'd2;
            r_frag  <= 1'b0;
            r_count <= '0;
            r_tlen  <= '0;
            r_given <= 1'b0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_nhp   <= n_nhp;
            r_frag  <= n_frag;
            r_count <= n_count;
            r_tlen  <= n_tlen;
            r_given <= n_given;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && out_load) begin
            r_found <= n_found;
            r_index <= n_index;
            r_bytes <= n_bytes;
        end
    end

    // a located bank always lies past the event header
    a_found_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_data_index >= IDX_W'(3)))
        else $error("found result with index inside event header");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_data_index == '0 && o_byte_count == '0))
        else $error("not-found result carries payload");

    a_given_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_given |-> (r_phase == PH_DONE))
        else $error("result given but search still running");

    a_len_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) == (r_pos == '0))
        else $error("length phase out of step with word position");

    a_one_per_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_given) |-> !(out_load && n_found))
        else $error("second found result in one event");

endmodule
